// ===== rtl/core/bto_pkg.sv =====
// ----------------------------------------------------------------------------
// bto_pkg
// Shared constants, codes and types of the blocked tensor offset unit.
// ----------------------------------------------------------------------------
package bto_pkg;

   localparam int MAX_DIMS   = 5;
   localparam int NUM_COORDS = 5;

   localparam int SIZE_W   = 16;
   localparam int SRC_W    = 3;
   localparam int RANK_W   = 3;
   localparam int OFF_W    = 48;
   localparam int STRIDE_W = 32;
   localparam int BASE_W   = 32;

   // divider: quotient bits retired per register stage
   localparam int DIV_BPS    = 4;
   localparam int DIV_STAGES = OFF_W / DIV_BPS;

   // multiplier split of the 48-bit factor into two halves
   localparam int MAC_SPLIT  = OFF_W / 2;
   localparam int PROD_W     = MAC_SPLIT + STRIDE_W;
   localparam int FULL_W     = PROD_W + MAC_SPLIT;
   localparam int MAC_STAGES = 3 + MAX_DIMS;

   // entry register, linear split, blocked split, multiply-accumulate
   localparam int PIPE_DEPTH = 1 + 2 * MAX_DIMS * DIV_STAGES + MAC_STAGES;
   localparam int FLIGHT_W   = $clog2(PIPE_DEPTH + 1);

   localparam logic [OFF_W-1:0] OFF_LIMIT = '1;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_COORD  = 2'd1,
      OP_LINEAR = 2'd2,
      OP_RSVD   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_LAYOUT = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   localparam logic [1:0] CSR_LOGICAL_RANK = 2'd0;
   localparam logic [1:0] CSR_BLOCKED_RANK = 2'd1;
   localparam logic [1:0] CSR_BASE_OFFSET  = 2'd2;

   // item context that travels down the divider chains
   typedef struct packed {
      logic                           lin_mode;
      logic [OFF_W-1:0]               lin;
      logic [MAX_DIMS-1:0][OFF_W-1:0] crd;
      logic [MAX_DIMS-1:0][OFF_W-1:0] shift;
   } ctx_type;

   function automatic logic [RANK_W-1:0] clamp_rank(input logic [RANK_W-1:0] r);
      logic [RANK_W-1:0] res;
      res = r;
      if (int'(r) > MAX_DIMS)
         res = RANK_W'(MAX_DIMS);
      return res;
   endfunction

   // coordinate picked by a source dimension; out of range reads zero
   function automatic logic [OFF_W-1:0] sel_coord(input ctx_type c,
                                                  input logic [SRC_W-1:0] src);
      logic [OFF_W-1:0] res;
      res = '0;
      for (int j = 0; j < MAX_DIMS; j++)
         if (src == SRC_W'(j))
            res = c.crd[j];
      return res;
   endfunction

endpackage

// ===== rtl/core/bto_divider.sv =====
// ----------------------------------------------------------------------------
// bto_divider
// Pipelined restoring divider, 48-bit dividend by 16-bit divisor, four
// quotient bits per stage; carries an item context alongside.
// ----------------------------------------------------------------------------
module bto_divider
   import bto_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  ctx_type           in_ctx,
   input  logic [OFF_W-1:0]  in_dividend,
   input  logic [SIZE_W-1:0] divisor,      // stable while items are in flight
   output logic              out_valid,
   output ctx_type           out_ctx,
   output logic [OFF_W-1:0]  out_quotient,
   output logic [SIZE_W-1:0] out_remainder
);

   logic              valid_ff [DIV_STAGES];
   ctx_type           ctx_ff   [DIV_STAGES];
   logic [SIZE_W-1:0] rem_ff   [DIV_STAGES];
   logic [OFF_W-1:0]  work_ff  [DIV_STAGES];

   logic              valid_src [DIV_STAGES];
   ctx_type           ctx_src   [DIV_STAGES];
   logic [SIZE_W-1:0] rem_src   [DIV_STAGES];
   logic [OFF_W-1:0]  work_src  [DIV_STAGES];

   logic [SIZE_W-1:0] rem_in  [DIV_STAGES];
   logic [OFF_W-1:0]  work_in [DIV_STAGES];

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
      if (g == 0) begin : g_head
         assign valid_src[g] = in_valid;
         assign ctx_src[g]   = in_ctx;
         assign rem_src[g]   = '0;
         assign work_src[g]  = in_dividend;
      end else begin : g_body
         assign valid_src[g] = valid_ff[g-1];
         assign ctx_src[g]   = ctx_ff[g-1];
         assign rem_src[g]   = rem_ff[g-1];
         assign work_src[g]  = work_ff[g-1];
      end

      // shift in one dividend bit, subtract the divisor where it fits
      always_comb begin
         logic [SIZE_W:0]   trial;
         logic [SIZE_W-1:0] rem;
         logic [OFF_W-1:0]  work;
         rem   = rem_src[g];
         work  = work_src[g];
         trial = '0;
         for (int b = 0; b < DIV_BPS; b++) begin
            trial = {rem, work[OFF_W-1]};
            work  = {work[OFF_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
               rem     = SIZE_W'(trial - {1'b0, divisor});
               work[0] = 1'b1;
            end else begin
               rem = trial[SIZE_W-1:0];
            end
         end
         rem_in[g]  = rem;
         work_in[g] = work;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= valid_src[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ctx_ff[g]  <= ctx_src[g];
            rem_ff[g]  <= rem_in[g];
            work_ff[g] <= work_in[g];
         end
      end
   end

   assign out_valid     = valid_ff[DIV_STAGES-1];
   assign out_ctx       = ctx_ff[DIV_STAGES-1];
   assign out_quotient  = work_ff[DIV_STAGES-1];
   assign out_remainder = rem_ff[DIV_STAGES-1];

endmodule

// ===== rtl/core/bto_mac.sv =====
// ----------------------------------------------------------------------------
// bto_mac
// Per-slot (shift + pad) * stride products and a saturating accumulation
// onto the base offset.
// ----------------------------------------------------------------------------
module bto_mac
   import bto_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  ctx_type                           in_ctx,
   input  logic [RANK_W-1:0]                 nb,
   input  logic [BASE_W-1:0]                 base_offset,
   input  logic [MAX_DIMS-1:0][SIZE_W-1:0]   pads,
   input  logic [MAX_DIMS-1:0][STRIDE_W-1:0] strides,
   output logic                              out_valid,
   output logic [OFF_W-1:0]                  out_offset,
   output status_type                        out_status
);

   // stage A: padded shift
   logic                           va_ff;
   logic [MAX_DIMS-1:0][OFF_W:0]   p_ff, p_in;
   // stage B: half products
   logic                           vb_ff;
   logic [MAX_DIMS-1:0][PROD_W-1:0] hi_ff, hi_in, lo_ff, lo_in;
   logic [MAX_DIMS-1:0]            top_ff, top_in;
   // stage C: full products
   logic                           vc_ff;
   logic [MAX_DIMS-1:0][OFF_W-1:0] prod_ff, prod_in;
   logic [MAX_DIMS-1:0]            big_ff, big_in;
   // accumulation chain, one slot per stage
   logic                           acc_valid_ff [MAX_DIMS];
   logic [OFF_W-1:0]               acc_sum_ff   [MAX_DIMS];
   logic [OFF_W-1:0]               acc_sum_in   [MAX_DIMS];
   logic                           acc_ovf_ff   [MAX_DIMS];
   logic                           acc_ovf_in   [MAX_DIMS];
   logic [MAX_DIMS-1:0][OFF_W-1:0] acc_prod_ff  [MAX_DIMS];
   logic [MAX_DIMS-1:0]            acc_big_ff   [MAX_DIMS];

   logic                           src_valid [MAX_DIMS];
   logic [OFF_W-1:0]               src_sum   [MAX_DIMS];
   logic                           src_ovf   [MAX_DIMS];
   logic [MAX_DIMS-1:0][OFF_W-1:0] src_prod  [MAX_DIMS];
   logic [MAX_DIMS-1:0]            src_big   [MAX_DIMS];

   always_comb begin
      for (int k = 0; k < MAX_DIMS; k++) begin
         p_in[k]  = {1'b0, in_ctx.shift[k]} + (OFF_W+1)'(pads[k]);
         hi_in[k] = PROD_W'(p_ff[k][OFF_W-1:MAC_SPLIT]) * PROD_W'(strides[k]);
         lo_in[k] = PROD_W'(p_ff[k][MAC_SPLIT-1:0]) * PROD_W'(strides[k]);
         top_in[k] = p_ff[k][OFF_W] && (strides[k] != '0);
      end
   end

   always_comb begin
      logic [FULL_W-1:0] full;
      full = '0;
      for (int k = 0; k < MAX_DIMS; k++) begin
         full = {hi_ff[k], {MAC_SPLIT{1'b0}}} + FULL_W'(lo_ff[k]);
         if (k < int'(nb)) begin
            prod_in[k] = full[OFF_W-1:0];
            big_in[k]  = top_ff[k] || (full[FULL_W-1:OFF_W] != '0);
         end else begin
            prod_in[k] = '0;
            big_in[k]  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff    <= p_in;
         hi_ff   <= hi_in;
         lo_ff   <= lo_in;
         top_ff  <= top_in;
         prod_ff <= prod_in;
         big_ff  <= big_in;
      end
   end

   for (genvar g = 0; g < MAX_DIMS; g++) begin : g_acc
      if (g == 0) begin : g_head
         assign src_valid[g] = vc_ff;
         assign src_sum[g]   = OFF_W'(base_offset);
         assign src_ovf[g]   = 1'b0;
         assign src_prod[g]  = prod_ff;
         assign src_big[g]   = big_ff;
      end else begin : g_body
         assign src_valid[g] = acc_valid_ff[g-1];
         assign src_sum[g]   = acc_sum_ff[g-1];
         assign src_ovf[g]   = acc_ovf_ff[g-1];
         assign src_prod[g]  = acc_prod_ff[g-1];
         assign src_big[g]   = acc_big_ff[g-1];
      end

      // partial sums only grow: a carry out anywhere means the total overflows
      always_comb begin
         logic [OFF_W:0] wide;
         wide           = {1'b0, src_sum[g]} + {1'b0, src_prod[g][g]};
         acc_sum_in[g]  = wide[OFF_W-1:0];
         acc_ovf_in[g]  = src_ovf[g] || src_big[g][g] || wide[OFF_W];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            acc_valid_ff[g] <= 1'b0;
         end else if (en) begin
            acc_valid_ff[g] <= src_valid[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            acc_sum_ff[g]  <= acc_sum_in[g];
            acc_ovf_ff[g]  <= acc_ovf_in[g];
            acc_prod_ff[g] <= src_prod[g];
            acc_big_ff[g]  <= src_big[g];
         end
      end
   end

   assign out_valid = acc_valid_ff[MAX_DIMS-1];

   always_comb begin
      priority if (nb == '0) begin
         out_offset = '0;
         out_status = ST_NO_LAYOUT;
      end else if (acc_ovf_ff[MAX_DIMS-1]) begin
         out_offset = OFF_LIMIT;
         out_status = ST_OVERFLOW;
      end else begin
         out_offset = acc_sum_ff[MAX_DIMS-1];
         out_status = ST_OK;
      end
   end

endmodule

// ===== rtl/core/blocked_tensor_offset.sv =====
// ----------------------------------------------------------------------------
// blocked_tensor_offset
// Element offset generator for blocked tensor layouts.
// ----------------------------------------------------------------------------
// Takes one coordinate or linear-index beat per cycle while the pipeline
// advances and returns one offset beat per item, in order, through one entry
// register, 60 stages that split a linear index over the logical sizes, 60
// stages that split coordinates over the blocked sizes (a 12-stage divider
// for each dimension and each slot, four quotient bits per stage), 8 stages
// of multiply and saturating accumulate, and a two-entry output buffer. The
// pipeline advances while that buffer has room, so one offset waiting on the
// result side does not hold up the input, but a full buffer does. Descriptor
// load beats are taken only while no offset item is in flight, because every
// stage reads the descriptor table directly; op code 3 beats are taken and
// dropped. Write the configuration registers only while the block is idle.
//
// req_tuser : op
// req_tdata : slot, logical_size, blocked_size, source_dim, wide_value, pad,
//             coord_0 .. coord_4 (lowest bit up), two zero pad bits on top
// rsp_tdata : element_offset
// rsp_tuser : status (0 ok, 1 no layout, 2 overflow saturated)
// ----------------------------------------------------------------------------
module blocked_tensor_offset
   import bto_pkg::*;
(
   input  logic          clock,
   input  logic          reset,

   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [183:0]  req_tdata,   // slot, logical_size, blocked_size, source_dim,
                                      // wide_value, pad, coord_0..coord_4
   input  logic [1:0]    req_tuser,   // op

   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [47:0]   rsp_tdata,   // element_offset
   output logic [1:0]    rsp_tuser,   // status

   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [31:0]   csr_wdata
);

   localparam int TD_SLOT_LSB  = 0;
   localparam int TD_LSIZE_LSB = TD_SLOT_LSB + SRC_W;
   localparam int TD_BSIZE_LSB = TD_LSIZE_LSB + SIZE_W;
   localparam int TD_SRC_LSB   = TD_BSIZE_LSB + SIZE_W;
   localparam int TD_WIDE_LSB  = TD_SRC_LSB + SRC_W;
   localparam int TD_PAD_LSB   = TD_WIDE_LSB + OFF_W;
   localparam int TD_CRD_LSB   = TD_PAD_LSB + SIZE_W;

   // configuration
   logic [RANK_W-1:0] logical_rank_ff;
   logic [RANK_W-1:0] blocked_rank_ff;
   logic [BASE_W-1:0] base_offset_ff;
   logic [RANK_W-1:0] nl, nb;

   // descriptor table, undefined until written
   logic [MAX_DIMS-1:0][SIZE_W-1:0]   logical_size_ff;
   logic [MAX_DIMS-1:0][SIZE_W-1:0]   blocked_size_ff;
   logic [MAX_DIMS-1:0][SRC_W-1:0]    source_dim_ff;
   logic [MAX_DIMS-1:0][STRIDE_W-1:0] stride_ff;
   logic [MAX_DIMS-1:0][SIZE_W-1:0]   pad_ff;

   // input side
   op_type            req_op;
   logic [SRC_W-1:0]  req_slot;
   logic              is_compute;
   logic              accept;
   logic              en;
   logic [FLIGHT_W-1:0] flight_ff, flight_in;

   // entry stage
   logic    ent_valid_ff;
   ctx_type ent_ctx_ff, ent_ctx_in;

   // linear split chain
   logic              lin_src_valid [MAX_DIMS];
   ctx_type           lin_src_ctx   [MAX_DIMS];
   logic              lin_div_valid [MAX_DIMS];
   ctx_type           lin_div_ctx   [MAX_DIMS];
   ctx_type           lin_wb_ctx    [MAX_DIMS];
   logic [OFF_W-1:0]  lin_quo       [MAX_DIMS];
   logic [SIZE_W-1:0] lin_rem       [MAX_DIMS];

   // blocked split chain
   logic              blk_src_valid [MAX_DIMS];
   ctx_type           blk_src_ctx   [MAX_DIMS];
   logic [OFF_W-1:0]  blk_dvd       [MAX_DIMS];
   logic              blk_div_valid [MAX_DIMS];
   ctx_type           blk_div_ctx   [MAX_DIMS];
   ctx_type           blk_wb_ctx    [MAX_DIMS];
   logic [OFF_W-1:0]  blk_quo       [MAX_DIMS];
   logic [SIZE_W-1:0] blk_rem       [MAX_DIMS];

   // accumulate and output buffer
   logic              mac_valid;
   logic [OFF_W-1:0]  mac_offset;
   status_type        mac_status;
   logic              push, pop;
   logic [OFF_W-1:0]  obuf_off_ff [2];
   status_type        obuf_st_ff  [2];
   logic              obuf_wr_ff, obuf_rd_ff;
   logic [1:0]        obuf_cnt_ff, obuf_cnt_in;

   assign nl = clamp_rank(logical_rank_ff);
   assign nb = clamp_rank(blocked_rank_ff);

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         logical_rank_ff <= RANK_W'(4);
         blocked_rank_ff <= '0;
         base_offset_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOGICAL_RANK: logical_rank_ff <= csr_wdata[RANK_W-1:0];
            CSR_BLOCKED_RANK: blocked_rank_ff <= csr_wdata[RANK_W-1:0];
            CSR_BASE_OFFSET:  base_offset_ff  <= csr_wdata[BASE_W-1:0];
            default: ;  // no register there: drop the write
         endcase
      end
   end

   // ---------------------------------------------------------------- input
   assign req_op     = op_type'(req_tuser);
   assign req_slot   = req_tdata[TD_SLOT_LSB +: SRC_W];
   assign is_compute = (req_op == OP_COORD) || (req_op == OP_LINEAR);

   // advance everything while the output buffer can take one more beat
   assign en = (obuf_cnt_ff != 2'd2);

   // hold a descriptor load until no offset item still reads the table
   assign req_tready = en && !((req_op == OP_LOAD) && (flight_ff != '0));
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (accept && (req_op == OP_LOAD)) begin
         for (int j = 0; j < MAX_DIMS; j++) begin
            if (req_slot == SRC_W'(j)) begin
               logical_size_ff[j] <= req_tdata[TD_LSIZE_LSB +: SIZE_W];
               blocked_size_ff[j] <= req_tdata[TD_BSIZE_LSB +: SIZE_W];
               source_dim_ff[j]   <= req_tdata[TD_SRC_LSB +: SRC_W];
               stride_ff[j]       <= req_tdata[TD_WIDE_LSB +: STRIDE_W];
               pad_ff[j]          <= req_tdata[TD_PAD_LSB +: SIZE_W];
            end
         end
      end
   end

   // items between acceptance and the output buffer
   always_comb begin
      flight_in = flight_ff;
      unique case ({accept && is_compute, push})
         2'b10:   flight_in = flight_ff + FLIGHT_W'(1);
         2'b01:   flight_in = flight_ff - FLIGHT_W'(1);
         default: flight_in = flight_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flight_ff <= '0;
      end else begin
         flight_ff <= flight_in;
      end
   end

   // ---------------------------------------------------------------- entry
   // coordinates beyond the logical rank enter as zero; a linear index
   // starts with all coordinates zero and fills them in the split chain
   always_comb begin
      ent_ctx_in          = '0;
      ent_ctx_in.lin_mode = (req_op == OP_LINEAR);
      ent_ctx_in.lin      = req_tdata[TD_WIDE_LSB +: OFF_W];
      for (int i = 0; i < MAX_DIMS; i++) begin
         if ((i < NUM_COORDS) && (i < int'(nl)) && (req_op == OP_COORD))
            ent_ctx_in.crd[i] = OFF_W'(req_tdata[TD_CRD_LSB + SIZE_W*i +: SIZE_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
      end else if (en) begin
         ent_valid_ff <= accept && is_compute;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ent_ctx_ff <= ent_ctx_in;
      end
   end

   // ---------------------------------------------------------------- linear split
   // last logical dimension first; dimensions at or beyond the rank pass
   for (genvar i = 0; i < MAX_DIMS; i++) begin : g_lin
      localparam int D = MAX_DIMS - 1 - i;

      if (i == 0) begin : g_head
         assign lin_src_valid[i] = ent_valid_ff;
         assign lin_src_ctx[i]   = ent_ctx_ff;
      end else begin : g_body
         assign lin_src_valid[i] = lin_div_valid[i-1];
         assign lin_src_ctx[i]   = lin_wb_ctx[i-1];
      end

      bto_divider u_div (
         .clock         (clock),
         .reset         (reset),
         .en            (en),
         .in_valid      (lin_src_valid[i]),
         .in_ctx        (lin_src_ctx[i]),
         .in_dividend   (lin_src_ctx[i].lin),
         .divisor       (logical_size_ff[D]),
         .out_valid     (lin_div_valid[i]),
         .out_ctx       (lin_div_ctx[i]),
         .out_quotient  (lin_quo[i]),
         .out_remainder (lin_rem[i])
      );

      // zero size: the dimension takes the whole remaining index
      always_comb begin
         lin_wb_ctx[i] = lin_div_ctx[i];
         if (lin_div_ctx[i].lin_mode && (D < int'(nl))) begin
            if (logical_size_ff[D] == '0) begin
               lin_wb_ctx[i].crd[D] = lin_div_ctx[i].lin;
               lin_wb_ctx[i].lin    = '0;
            end else begin
               lin_wb_ctx[i].crd[D] = OFF_W'(lin_rem[i]);
               lin_wb_ctx[i].lin    = lin_quo[i];
            end
         end
      end
   end

   // ---------------------------------------------------------------- blocked split
   // last blocked slot first; each slot divides its source coordinate down
   for (genvar i = 0; i < MAX_DIMS; i++) begin : g_blk
      localparam int S = MAX_DIMS - 1 - i;

      if (i == 0) begin : g_head
         assign blk_src_valid[i] = lin_div_valid[MAX_DIMS-1];
         assign blk_src_ctx[i]   = lin_wb_ctx[MAX_DIMS-1];
      end else begin : g_body
         assign blk_src_valid[i] = blk_div_valid[i-1];
         assign blk_src_ctx[i]   = blk_wb_ctx[i-1];
      end

      assign blk_dvd[i] = sel_coord(blk_src_ctx[i], source_dim_ff[S]);

      bto_divider u_div (
         .clock         (clock),
         .reset         (reset),
         .en            (en),
         .in_valid      (blk_src_valid[i]),
         .in_ctx        (blk_src_ctx[i]),
         .in_dividend   (blk_dvd[i]),
         .divisor       (blocked_size_ff[S]),
         .out_valid     (blk_div_valid[i]),
         .out_ctx       (blk_div_ctx[i]),
         .out_quotient  (blk_quo[i]),
         .out_remainder (blk_rem[i])
      );

      // zero blocked size: shift is the whole coordinate, coordinate drops to zero;
      // a source dimension out of range gives a zero shift and updates no coordinate
      always_comb begin
         blk_wb_ctx[i] = blk_div_ctx[i];
         if (S < int'(nb)) begin
            if (blocked_size_ff[S] == '0) begin
               blk_wb_ctx[i].shift[S] = sel_coord(blk_div_ctx[i], source_dim_ff[S]);
            end else begin
               blk_wb_ctx[i].shift[S] = OFF_W'(blk_rem[i]);
            end
            for (int j = 0; j < MAX_DIMS; j++) begin
               if (source_dim_ff[S] == SRC_W'(j))
                  blk_wb_ctx[i].crd[j] = (blocked_size_ff[S] == '0) ? '0 : blk_quo[i];
            end
         end
      end
   end

   // ---------------------------------------------------------------- accumulate
   bto_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (blk_div_valid[MAX_DIMS-1]),
      .in_ctx      (blk_wb_ctx[MAX_DIMS-1]),
      .nb          (nb),
      .base_offset (base_offset_ff),
      .pads        (pad_ff),
      .strides     (stride_ff),
      .out_valid   (mac_valid),
      .out_offset  (mac_offset),
      .out_status  (mac_status)
   );

   // ---------------------------------------------------------------- output buffer
   assign push = en && mac_valid;
   assign pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      unique case ({push, pop})
         2'b10:   obuf_cnt_in = obuf_cnt_ff + 2'd1;
         2'b01:   obuf_cnt_in = obuf_cnt_ff - 2'd1;
         default: obuf_cnt_in = obuf_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         obuf_cnt_ff <= '0;
         obuf_wr_ff  <= 1'b0;
         obuf_rd_ff  <= 1'b0;
      end else begin
         obuf_cnt_ff <= obuf_cnt_in;
         if (push)
            obuf_wr_ff <= !obuf_wr_ff;
         if (pop)
            obuf_rd_ff <= !obuf_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         obuf_off_ff[obuf_wr_ff] <= mac_offset;
         obuf_st_ff[obuf_wr_ff]  <= mac_status;
      end
   end

   assign rsp_tvalid = (obuf_cnt_ff != 2'd0);
   assign rsp_tdata  = obuf_off_ff[obuf_rd_ff];
   assign rsp_tuser  = obuf_st_ff[obuf_rd_ff];

endmodule

// ===== rtl/core/bto_checker.sv =====
// ----------------------------------------------------------------------------
// bto_checker
// Port-level checks on the result channel of the blocked tensor offset unit.
// ----------------------------------------------------------------------------
module bto_checker
   import bto_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // a stalled beat holds its offset
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_no_layout: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_NO_LAYOUT) |-> (rsp_tdata == '0))
      else $error("no-layout beat with nonzero offset");

   a_saturate: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_OVERFLOW) |-> (rsp_tdata == OFF_LIMIT))
      else $error("overflow beat not saturated");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ST_OK) || (rsp_tuser == ST_NO_LAYOUT) ||
                     (rsp_tuser == ST_OVERFLOW))
      else $error("undefined status code");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

endmodule

bind blocked_tensor_offset bto_checker u_bto_checker (.*);

// ===== tb/sv/bto_checker.sv =====
// ----------------------------------------------------------------------------
// bto_scoreboard
// Watches the request, response and register ports of the offset unit. It
// keeps its own copy of the descriptor table and of the registers, works out
// the offset that each accepted coordinate or linear-index beat should give,
// and compares every response beat with the oldest offset still owed.
// ----------------------------------------------------------------------------
module bto_scoreboard
   import bto_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [183:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [47:0]  rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata,
   output int           mismatches,
   output int           owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [47:0] offset;
      status_type  status;
   } offset_beat;

   logic [2:0]  lrank_reg = 3'd4;
   logic [2:0]  brank_reg = 3'd0;
   logic [31:0] base_reg  = '0;

   logic [15:0] lsize_tab [MAX_DIMS];
   logic [15:0] bsize_tab [MAX_DIMS];
   logic [2:0]  src_tab   [MAX_DIMS];
   logic [31:0] stride_tab[MAX_DIMS];
   logic [15:0] pad_tab   [MAX_DIMS];

   offset_beat  owed_offsets[$];
   int          err_count = 0;

   assign mismatches = err_count;
   assign owed       = owed_offsets.size();

   function automatic offset_beat calc_offset(input logic [1:0] op, input logic [183:0] d);
      offset_beat   res;
      logic [63:0]  crd[MAX_DIMS];
      logic [63:0]  shift[MAX_DIMS];
      logic [63:0]  lin;
      logic [63:0]  c;
      logic [127:0] prod;
      logic [127:0] sum;
      int           nl;
      int           nb;
      int           sd;
      nl = (lrank_reg > MAX_DIMS) ? MAX_DIMS : int'(lrank_reg);
      nb = (brank_reg > MAX_DIMS) ? MAX_DIMS : int'(brank_reg);
      for (int i = 0; i < MAX_DIMS; i++) crd[i] = '0;
      if (op == OP_COORD) begin
         for (int i = 0; i < nl; i++) crd[i] = 64'(d[102 + 16*i +: 16]);
      end else begin
         lin = 64'(d[85:38]);
         for (int i = nl - 1; i >= 0; i--) begin
            if (lsize_tab[i] == 0) begin
               crd[i] = lin;
               lin    = '0;
            end else begin
               crd[i] = lin % lsize_tab[i];
               lin    = lin / lsize_tab[i];
            end
         end
      end
      if (nb == 0) begin
         res.offset = '0;
         res.status = ST_NO_LAYOUT;
         return res;
      end
      // split the coordinates over the blocked slots, innermost slot first
      for (int s = nb - 1; s >= 0; s--) begin
         sd = int'(src_tab[s]);
         c  = (sd < MAX_DIMS) ? crd[sd] : '0;
         if (bsize_tab[s] == 0) begin
            shift[s] = c;
            c        = '0;
         end else begin
            shift[s] = c % bsize_tab[s];
            c        = c / bsize_tab[s];
         end
         if (sd < MAX_DIMS) crd[sd] = c;
      end
      sum = 128'(base_reg);
      for (int s = 0; s < nb; s++) begin
         prod = 128'(shift[s] + pad_tab[s]) * 128'(stride_tab[s]);
         sum  = sum + prod;
         if (prod > 128'(OFF_LIMIT) || sum > 128'(OFF_LIMIT)) begin
            res.offset = OFF_LIMIT;
            res.status = ST_OVERFLOW;
            return res;
         end
      end
      res.offset = sum[47:0];
      res.status = ST_OK;
      return res;
   endfunction

   always @(posedge clock) begin
      offset_beat want;
      if (!reset) begin
         // check the response side first: an offset never leaves on its own input edge
         if (rsp_tvalid && rsp_tready) begin
            if (owed_offsets.size() == 0) begin
               err_count++;
               $display("%0t: unexpected offset beat, actual offset %h status %0d",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = owed_offsets.pop_front();
               if (rsp_tdata !== want.offset) begin
                  err_count++;
                  $display("%0t: offset mismatch, expected %h actual %h",
                           $time, want.offset, rsp_tdata);
               end
               if (rsp_tuser !== want.status) begin
                  err_count++;
                  $display("%0t: status mismatch, expected %0d actual %0d",
                           $time, want.status, rsp_tuser);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               OP_LOAD: begin
                  if (req_tdata[2:0] < MAX_DIMS) begin
                     lsize_tab [req_tdata[2:0]] = req_tdata[18:3];
                     bsize_tab [req_tdata[2:0]] = req_tdata[34:19];
                     src_tab   [req_tdata[2:0]] = req_tdata[37:35];
                     stride_tab[req_tdata[2:0]] = req_tdata[69:38];
                     pad_tab   [req_tdata[2:0]] = req_tdata[101:86];
                  end
               end
               OP_COORD, OP_LINEAR:
                  owed_offsets.insert(owed_offsets.size(), calc_offset(req_tuser, req_tdata));
               default: ;
            endcase
         end
         if (csr_we) begin
            case (csr_index)
               CSR_LOGICAL_RANK: lrank_reg = csr_wdata[2:0];
               CSR_BLOCKED_RANK: brank_reg = csr_wdata[2:0];
               CSR_BASE_OFFSET:  base_reg  = csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the blocked tensor offset unit.
// ----------------------------------------------------------------------------
// Loads the descriptor table, runs a directed set of edge cases, then several
// random phases, each with its own ranks, base offset and idle/stall mix.
// The checker beside the block predicts and compares every offset beat.
// ----------------------------------------------------------------------------
module testbench
   import bto_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 150;   // a bit over the depth of the pipe

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [183:0] req_tdata  = '0;   // slot, logical_size, blocked_size, source_dim,
                                    // wide_value, pad, coord_0..coord_4
   logic [1:0]   req_tuser  = '0;   // op
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [47:0]  rsp_tdata;         // element_offset
   logic [1:0]   rsp_tuser;         // status
   logic         csr_we     = 1'b0;
   logic [1:0]   csr_index  = '0;
   logic [31:0]  csr_wdata  = '0;

   int mismatches;
   int owed;
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;

   blocked_tensor_offset u_top (.*);

   bto_scoreboard u_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #20ms;
      $display("testbench: done, errors");
      $finish;
   end

   // receiver: stall at the rate of the current phase
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // hold the beat until accepted; idle first at the phase's rate
   task automatic send_beat(input op_type op, input logic [183:0] data);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic load_slot(input logic [2:0] slot, input logic [15:0] lsize,
                            input logic [15:0] bsize, input logic [2:0] src,
                            input logic [47:0] stride, input logic [15:0] pad);
      send_beat(OP_LOAD, {2'b00, 80'(0), pad, stride, src, bsize, lsize, slot});
   endtask

   task automatic send_coords(input logic [79:0] coords);
      send_beat(OP_COORD, {2'b00, coords, 16'(0), 48'(0), 3'(0), 16'(0), 16'(0), 3'(0)});
   endtask

   task automatic send_linear(input logic [47:0] index);
      send_beat(OP_LINEAR, {2'b00, 80'(0), 16'(0), index, 3'(0), 16'(0), 16'(0), 3'(0)});
   endtask

   // wait out every owed offset plus the pipe, so loads have landed too
   task automatic drain;
      req_tvalid <= 1'b0;
      while (owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // drive one register beat; the caller drops the write enable afterwards
   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_layout(input logic [2:0] lrank, input logic [2:0] brank,
                             input logic [31:0] base);
      write_reg(CSR_LOGICAL_RANK, 32'(lrank));
      write_reg(CSR_BLOCKED_RANK, 32'(brank));
      write_reg(CSR_BASE_OFFSET, base);
      csr_we <= 1'b0;
   endtask

   // field values biased toward zero, the maximum and small numbers
   function automatic logic [15:0] pick16;
      case ($urandom_range(7))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2, 3:    return 16'($urandom_range(1, 9));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [47:0] pick48;
      case ($urandom_range(7))
         0:       return 48'd0;
         1:       return '1;
         2, 3:    return 48'($urandom_range(0, 5000));
         default: return {16'($urandom), 32'($urandom)};
      endcase
   endfunction

   task automatic random_beat;
      logic [2:0]  slot;
      logic [79:0] coords;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 20) begin
         slot = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
         load_slot(slot, pick16(), pick16(),
                   ($urandom_range(7) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4)),
                   pick48(), pick16());
      end else if (pick < 58) begin
         for (int i = 0; i < NUM_COORDS; i++) coords[16*i +: 16] = pick16();
         send_coords(coords);
      end else if (pick < 95) begin
         send_linear(pick48());
      end else begin
         // reserved op with random payload: dropped by the block
         send_beat(OP_RSVD, {2'b00, 182'({$urandom, $urandom, $urandom, $urandom,
                                           $urandom, $urandom})});
      end
   endtask

   typedef struct {
      logic [2:0]  lrank;
      logic [2:0]  brank;
      logic [31:0] base;
      int          idle;
      int          stall;
   } phase_cfg;

   phase_cfg phases[8];

   initial begin
      phases[0] = '{3'd5, 3'd5, 32'hFFFF_FFFF, 0,  0};
      phases[1] = '{3'd1, 3'd0, 32'd0,         58, 0};
      phases[2] = '{3'd0, 3'd1, 32'd17,        0,  58};
      phases[3] = '{3'd7, 3'd6, 32'h8000_0000, 13, 13};
      phases[4] = '{3'd3, 3'd3, 32'd1,         0,  0};
      phases[5] = '{3'd5, 3'd2, 32'h1234_5678, 58, 0};
      phases[6] = '{3'd2, 3'd5, 32'd0,         0,  58};
      phases[7] = '{3'd4, 3'd4, 32'hFFFF_FFFF, 13, 13};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every slot before any offset reads the table
      set_layout(3'd5, 3'd5, 32'hFFFF_FFFF);
      load_slot(3'd0, 16'hFFFF, 16'd1,     3'd0, 48'd1,            16'd0);
      load_slot(3'd1, 16'd1,    16'hFFFF,  3'd1, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
      load_slot(3'd2, 16'd0,    16'd0,     3'd2, 48'd7,            16'd3);
      load_slot(3'd3, 16'd16,   16'd4,     3'd7, 48'd0,            16'd1);
      load_slot(3'd4, 16'd3,    16'd2,     3'd4, 48'hABCD_0000_0064, 16'd2);
      // loads past the table and the reserved op: dropped
      load_slot(3'd5, 16'd9,    16'd9,     3'd0, 48'd9,            16'd9);
      load_slot(3'd7, 16'd9,    16'd9,     3'd0, 48'd9,            16'd9);
      send_beat(OP_RSVD, '1 >> 2);
      // overflow through the huge stride of slot 1
      send_coords('1);
      send_coords('0);
      send_linear('1);
      send_linear(48'd0);
      send_linear(48'd123_456_789);
      // tame slot 1 so sums stay in range
      load_slot(3'd1, 16'd1, 16'hFFFF, 3'd1, 48'd1, 16'd0);
      send_coords({16'd5, 16'd4, 16'd3, 16'd2, 16'd1});
      send_coords('1);
      send_linear(48'd77);
      send_linear('1);
      drain();
      set_layout(3'd5, 3'd0, 32'd0);
      send_coords('1);
      send_linear(48'd5);
      drain();

      foreach (phases[p]) begin
         set_layout(phases[p].lrank, phases[p].brank, phases[p].base);
         send_idle_pct = phases[p].idle;
         rsp_stall_pct = phases[p].stall;
         repeat (200) random_beat();
         drain();
      end

      if (mismatches == 0 && owed == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
